>>> src/r64a_pkg.sv
// Shared types, constants and symbol lookup for the radix-64 armor encoder.
package r64a_pkg;

  localparam logic [23:0] CRC_INIT_RST = 24'hB704CE;
  localparam logic [23:0] CRC_POLY_RST = 24'h864CFB;
  localparam logic [9:0]  SEC_LINES_RST = 10'd0;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CRC_INIT  = 2'd0;
  localparam logic [1:0] REG_CRC_POLY  = 2'd1;
  localparam logic [1:0] REG_SEC_LINES = 2'd2;

  // Job queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Back-end character slots: four group chars, then '=' and four CRC chars.
  localparam logic [3:0] STEP_GRP_LAST = 4'd3;
  localparam logic [3:0] STEP_CRC_PAD  = 4'd4;
  localparam logic [3:0] STEP_CRC_LAST = 4'd8;

  typedef struct packed {
    logic [23:0] word;      // group bytes, left-aligned
    logic [1:0]  fill;      // bytes in the group, 1..3
    logic        line_end;  // group closes the line
    logic        crc_line;  // checksum line follows
    logic [23:0] crc;       // checksum of the section
  } r64a_job_t;

  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] c;
    c = 8'h00;
    case (v) inside
      [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:         c = 8'h2B;
      6'd63:         c = 8'h2F;
      default:       c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> src/r64a_front.sv
// Front end: takes bytes, runs the CRC, groups bytes into jobs and marks each job's line and checksum ends.
module r64a_front #(
  parameter int unsigned LINE_BYTES = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_final_byte,
  input  logic [23:0]        crc_init,
  input  logic [23:0]        crc_poly,
  input  logic [9:0]         section_lines,
  input  logic               q_full,
  output logic               q_push,
  output r64a_pkg::r64a_job_t q_job
);
  import r64a_pkg::*;

  localparam int unsigned LBC_W = $clog2(LINE_BYTES + 1);
  localparam logic [LBC_W-1:0] LINE_LIMIT = LBC_W'(LINE_BYTES);

  logic [15:0]      held_r, held_nxt;
  logic [1:0]       gfill_r, gfill_nxt;
  logic [LBC_W-1:0] lbc_r, lbc_nxt;
  logic [9:0]       slc_r, slc_nxt;
  logic [23:0]      crc_r, crc_nxt;

  logic             accept;
  logic [23:0]      crc_new;
  logic [1:0]       fill;
  logic [LBC_W-1:0] lbc_inc;
  logic [9:0]       slc_inc;
  logic             line_full, do_grp, le, close, crc_line;
  logic [23:0]      word;

  function automatic logic [23:0] crc_byte(input logic [23:0] c_in, input logic [7:0] b,
                                           input logic [23:0] poly);
    logic [23:0] c;
    c = c_in ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      if (c[23]) c = {c[22:0], 1'b0} ^ poly;
      else       c = {c[22:0], 1'b0};
    end
    return c;
  endfunction

  always_comb begin
    accept    = in_valid && !q_full;
    crc_new   = crc_byte(crc_r, in_data_byte, crc_poly);
    fill      = gfill_r + 2'd1;
    lbc_inc   = lbc_r + LBC_W'(1);
    slc_inc   = slc_r + 10'd1;
    line_full = lbc_inc >= LINE_LIMIT;
    do_grp    = (fill == 2'd3) || line_full || in_final_byte;
    le        = line_full || in_final_byte;
    close     = le && (section_lines != 10'd0) && (slc_inc >= section_lines);
    crc_line  = close || in_final_byte;

    case (fill)
      2'd1:    word = {in_data_byte, 16'h0000};
      2'd2:    word = {held_r[7:0], in_data_byte, 8'h00};
      default: word = {held_r, in_data_byte};
    endcase

    held_nxt  = held_r;
    gfill_nxt = gfill_r;
    lbc_nxt   = lbc_r;
    slc_nxt   = slc_r;
    crc_nxt   = crc_r;
    if (accept) begin
      crc_nxt = crc_line ? crc_init : crc_new;
      if (do_grp) begin
        held_nxt  = 16'h0000;
        gfill_nxt = 2'd0;
        if (le) begin
          lbc_nxt = '0;
          slc_nxt = crc_line ? 10'd0 : slc_inc;
        end else begin
          lbc_nxt = lbc_inc;
        end
      end else begin
        held_nxt  = {held_r[7:0], in_data_byte};
        gfill_nxt = fill;
        lbc_nxt   = lbc_inc;
      end
    end

    in_stall          = q_full;
    q_push            = accept && do_grp;
    q_job.word        = word;
    q_job.fill        = fill;
    q_job.line_end    = le;
    q_job.crc_line    = crc_line;
    q_job.crc         = crc_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 16'h0000;
      gfill_r <= 2'd0;
      lbc_r   <= '0;
      slc_r   <= 10'd0;
      crc_r   <= CRC_INIT_RST;
    end else begin
      held_r  <= held_nxt;
      gfill_r <= gfill_nxt;
      lbc_r   <= lbc_nxt;
      slc_r   <= slc_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

>>> src/r64a_fifo.sv
// Short job queue between the front and back ends.
module r64a_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  r64a_pkg::r64a_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output r64a_pkg::r64a_job_t head_job
);
  import r64a_pkg::*;

  r64a_job_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wp_r, wp_nxt;
  logic [QPTR_W-1:0]  rp_r, rp_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  always_comb begin
    full       = cnt_r == QCNT_W'(QDEPTH);
    head_valid = cnt_r != '0;
    head_job   = mem_r[rp_r];
    do_push    = push && !full;
    do_pop     = pop && head_valid;
    wp_nxt     = do_push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt     = do_pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> src/r64a_back.sv
// Back end: walks jobs as chars, one per cycle unless stalled, to the output register.
module r64a_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  r64a_pkg::r64a_job_t q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_char,
  output logic                out_line_end,
  output logic                out_section_end,
  output logic                out_last_of_run
);
  import r64a_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       le_r, le_nxt;
  logic       se_r, se_nxt;
  logic       last_r, last_nxt;

  logic       advance, emit, last;
  logic [5:0] idx;

  always_comb begin
    advance = !valid_r || !out_stall;
    emit    = q_valid && advance;
    last    = q_job.crc_line ? (step_r == STEP_CRC_LAST) : (step_r == STEP_GRP_LAST);
    q_pop   = emit && last;

    case (step_r)
      4'd0:    idx = q_job.word[23:18];
      4'd1:    idx = q_job.word[17:12];
      4'd2:    idx = q_job.word[11:6];
      4'd3:    idx = q_job.word[5:0];
      4'd5:    idx = q_job.crc[23:18];
      4'd6:    idx = q_job.crc[17:12];
      4'd7:    idx = q_job.crc[11:6];
      default: idx = q_job.crc[5:0];
    endcase

    if (step_r <= STEP_GRP_LAST) begin
      // slots past the group's bytes become padding
      char_nxt = (step_r[1:0] <= q_job.fill) ? sym(idx) : PAD_CHAR;
      le_nxt   = (step_r == STEP_GRP_LAST) && q_job.line_end;
      se_nxt   = 1'b0;
    end else if (step_r == STEP_CRC_PAD) begin
      char_nxt = PAD_CHAR;
      le_nxt   = 1'b0;
      se_nxt   = 1'b0;
    end else begin
      char_nxt = sym(idx);
      le_nxt   = step_r == STEP_CRC_LAST;
      se_nxt   = step_r == STEP_CRC_LAST;
    end
    last_nxt = last;

    valid_nxt = advance ? q_valid : valid_r;
    step_nxt  = emit ? (last ? 4'd0 : step_r + 4'd1) : step_r;

    out_valid       = valid_r;
    out_char        = char_r;
    out_line_end    = le_r;
    out_section_end = se_r;
    out_last_of_run = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 4'd0;
    end else begin
      valid_r <= valid_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= char_nxt;
      le_r   <= le_nxt;
      se_r   <= se_nxt;
      last_r <= last_nxt;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_CRC_LAST)
    else $error("character slot out of range");

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 4'd0 |-> q_valid)
    else $error("job left the queue in mid walk");

  a_sec_end: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && se_r |-> le_r && last_r)
    else $error("section end without line end and run end");

  a_pop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> step_r == 4'd0)
    else $error("slot counter not rewound after job");

endmodule

>>> src/radix64_armour_encoder_crc24.sv
// Top level of the radix-64 armor encoder with CRC-24 checksum lines.
//
//   channel  | handshake                        | payload
//   in       | in_valid / in_stall              | in_data_byte, in_final_byte
//   out      | out_valid / out_stall            | out_char, out_line_end,
//            |                                  | out_section_end, out_last_of_run
//   config   | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// A byte is taken every cycle while the four-entry job queue has room; the CRC of
// a byte is done in the cycle it is taken. The output gives one character per
// cycle while out_stall is low, so the back end sets the sustained rate: four
// characters per group of three bytes, plus five for each checksum line. A byte
// passes through the job queue and the output register. Reset is synchronous;
// out_stall holds the output register and, once the queue fills, raises in_stall.
module radix64_armour_encoder_crc24 #(
  parameter int unsigned LINE_BYTES = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_line_end,
  output logic        out_section_end,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import r64a_pkg::*;

  logic [23:0] crc_init_r, crc_init_nxt;
  logic [23:0] crc_poly_r, crc_poly_nxt;
  logic [9:0]  sec_lines_r, sec_lines_nxt;
  logic        wr_en;

  logic        q_full, q_push, q_pop, q_valid;
  r64a_job_t   push_job, head_job;

  always_comb begin
    pready        = 1'b1;
    wr_en         = psel && penable && pwrite;
    crc_init_nxt  = crc_init_r;
    crc_poly_nxt  = crc_poly_r;
    sec_lines_nxt = sec_lines_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_CRC_INIT:  crc_init_nxt  = pwdata[23:0];
        REG_CRC_POLY:  crc_poly_nxt  = pwdata[23:0];
        REG_SEC_LINES: sec_lines_nxt = pwdata[9:0];
        default: ;
      endcase
    end
    case (paddr[3:2])
      REG_CRC_INIT:  prdata = {8'h00, crc_init_r};
      REG_CRC_POLY:  prdata = {8'h00, crc_poly_r};
      REG_SEC_LINES: prdata = {22'h0, sec_lines_r};
      default:       prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_init_r  <= CRC_INIT_RST;
      crc_poly_r  <= CRC_POLY_RST;
      sec_lines_r <= SEC_LINES_RST;
    end else begin
      crc_init_r  <= crc_init_nxt;
      crc_poly_r  <= crc_poly_nxt;
      sec_lines_r <= sec_lines_nxt;
    end
  end

  r64a_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .crc_init      (crc_init_r),
    .crc_poly      (crc_poly_r),
    .section_lines (sec_lines_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  r64a_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  r64a_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (head_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_line_end    (out_line_end),
    .out_section_end (out_section_end),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> dv/radix64_armour_encoder_crc24_checker.sv
// Scoreboard for the radix-64 armor encoder: predicts every character beat and compares.
module radix64_armour_encoder_crc24_checker #(
  parameter int unsigned LINE_BYTES = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_char,
  input  logic        out_line_end,
  input  logic        out_section_end,
  input  logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  import r64a_pkg::*;

  localparam logic [511:0] R64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    logic       section_end;
    logic       last_of_run;
  } armor_char_t;

  armor_char_t expected_chars[$];

  // Register copies
  logic [23:0] crc_init_reg;
  logic [23:0] crc_poly_reg;
  logic [9:0]  section_lines_reg;

  // Encoder state
  logic [15:0] held_bytes;
  logic [1:0]  group_fill;
  logic [7:0]  line_bytes;
  logic [9:0]  lines_done;
  logic [23:0] crc_acc;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [7:0] r64_symbol(input int v);
    return R64_ALPHABET[511 - 8 * v -: 8];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // Encode one input byte and queue the characters it produces.
  function automatic void armor_encode_byte(input logic [7:0] b, input logic fin);
    armor_char_t run_chars [9];
    int          n;
    logic [1:0]  fill;
    logic        line_done;
    logic        close_section;
    logic [23:0] word;
    n = 0;
    close_section = 1'b0;

    crc_acc = crc_acc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++)
      crc_acc = crc_acc[23] ? ((crc_acc << 1) ^ crc_poly_reg) : (crc_acc << 1);

    fill = (group_fill == 2'd3) ? 2'd3 : group_fill + 2'd1;
    line_bytes = line_bytes + 8'd1;
    line_done = (line_bytes >= LINE_BYTES) || fin;

    if (fill == 2'd3 || line_done) begin
      case (fill)
        2'd1:    word = {b, 16'h0000};
        2'd2:    word = {held_bytes[7:0], b, 8'h00};
        default: word = {held_bytes, b};
      endcase
      for (int k = 0; k < 4; k++) begin
        run_chars[n].ch = (k <= fill) ? r64_symbol(int'(word[23 - 6 * k -: 6])) : PAD_CHAR;
        run_chars[n].line_end = (k == 3) && line_done;
        run_chars[n].section_end = 1'b0;
        run_chars[n].last_of_run = 1'b0;
        n++;
      end
      held_bytes = '0;
      group_fill = '0;
      if (line_done) begin
        line_bytes = '0;
        lines_done = lines_done + 10'd1;
        if (section_lines_reg != '0 && lines_done >= section_lines_reg)
          close_section = 1'b1;
      end
    end else begin
      held_bytes = {held_bytes[7:0], b};
      group_fill = fill;
    end

    // Checksum line: pad marker, then four symbols of the CRC.
    if (close_section || fin) begin
      run_chars[n] = '0;
      run_chars[n].ch = PAD_CHAR;
      n++;
      for (int k = 0; k < 4; k++) begin
        run_chars[n].ch = r64_symbol(int'(crc_acc[23 - 6 * k -: 6]));
        run_chars[n].line_end = (k == 3);
        run_chars[n].section_end = (k == 3);
        run_chars[n].last_of_run = 1'b0;
        n++;
      end
      crc_acc = crc_init_reg;
      lines_done = '0;
      line_bytes = '0;
      held_bytes = '0;
      group_fill = '0;
    end

    if (n > 0)
      run_chars[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++)
      expected_chars.push_back(run_chars[i]);
  endfunction

  always @(posedge clk) begin : watch
    armor_char_t want;
    if (!rst_n) begin
      crc_init_reg = CRC_INIT_RST;
      crc_poly_reg = CRC_POLY_RST;
      section_lines_reg = SEC_LINES_RST;
      held_bytes = '0;
      group_fill = '0;
      line_bytes = '0;
      lines_done = '0;
      crc_acc = CRC_INIT_RST;
      expected_chars.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("char beat with nothing pending", int'(out_char), 0);
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch)
            report_mismatch("out_char", int'(out_char), int'(want.ch));
          if (out_line_end !== want.line_end)
            report_mismatch("out_line_end", int'(out_line_end), int'(want.line_end));
          if (out_section_end !== want.section_end)
            report_mismatch("out_section_end", int'(out_section_end),
                            int'(want.section_end));
          if (out_last_of_run !== want.last_of_run)
            report_mismatch("out_last_of_run", int'(out_last_of_run),
                            int'(want.last_of_run));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CRC_INIT:  crc_init_reg = pwdata[23:0];
          REG_CRC_POLY:  crc_poly_reg = pwdata[23:0];
          REG_SEC_LINES: section_lines_reg = pwdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        armor_encode_byte(in_data_byte, in_final_byte);
    end
    pending = expected_chars.size();
  end

endmodule

>>> dv/tb_radix64_armour_encoder_crc24.sv
// Testbench top for the radix-64 armor encoder: stimulus, register phases and verdict.
module tb_radix64_armour_encoder_crc24;
  import r64a_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = 12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        in_final_byte = 1'b0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_line_end;
  logic        out_section_end;
  logic        out_last_of_run;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit steady = 1'b0;
  bit hold_off_req = 1'b0;

  radix64_armour_encoder_crc24 i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_line_end    (out_line_end),
    .out_section_end (out_section_end),
    .out_last_of_run (out_last_of_run),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  radix64_armour_encoder_crc24_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_final_byte   (in_final_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_line_end    (out_line_end),
    .out_section_end (out_section_end),
    .out_last_of_run (out_last_of_run),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
  endtask

  // Random messages, mostly short, some spanning lines.
  task automatic send_stream(input int count, input bit with_final);
    int         left;
    logic [7:0] b;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0)
        left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(40, 110);
      left--;
      b = 8'($urandom_range(0, 255));
      send_byte(b, with_final && (left == 0));
    end
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [23:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {8'h00, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for all characters, then let held bytes settle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : out_stall_drive
    int len;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        len = HOLD_OFF_CYCLES;
      end else begin
        len = idle_len();
      end
      if (len != 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("radix64_armour_encoder_crc24 regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one-byte group, two-byte group, exact group, group plus partial
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h7F, 1'b1);
    settle();

    // One line per section; final byte lands on the limit line end
    apb_write(REG_CRC_INIT, 24'h000000);
    apb_write(REG_CRC_POLY, 24'hFFFFFF);
    apb_write(REG_SEC_LINES, 24'd1);
    send_message(48);
    send_stream(20, 1'b1);
    settle();

    // Widest limit, no idling on either side
    steady = 1'b1;
    apb_write(REG_CRC_INIT, 24'hFFFFFF);
    apb_write(REG_CRC_POLY, 24'h000000);
    apb_write(REG_SEC_LINES, 24'd1023);
    send_message(50);
    send_stream(10, 1'b1);
    settle();
    steady = 1'b0;

    // Random CRC settings; hold the output long enough to back up the input
    apb_write(REG_CRC_INIT, 24'($urandom_range(0, 24'hFFFFFF)));
    apb_write(REG_CRC_POLY, 24'($urandom_range(0, 24'hFFFFFF)));
    apb_write(REG_SEC_LINES, 24'd2);
    hold_off_req = 1'b1;
    send_stream(40, 1'b1);
    settle();

    // Back to reset values, unlimited, then lower the limit mid-section
    apb_write(REG_CRC_INIT, CRC_INIT_RST);
    apb_write(REG_CRC_POLY, CRC_POLY_RST);
    apb_write(REG_SEC_LINES, 24'(SEC_LINES_RST));
    send_stream(52, 1'b0);
    settle();
    apb_write(REG_SEC_LINES, 24'd1);
    send_stream(30, 1'b1);
    settle();

    if (fail_count == 0 && pending == 0)
      $display("radix64_armour_encoder_crc24 regression: pass");
    else
      $display("radix64_armour_encoder_crc24 regression: fail");
    $finish;
  end

endmodule
